[src/sawr_pkg.sv]
// Shared types and constants of the stop-and-wait receiver.
package sawr_pkg;

    // Input action codes
    localparam logic [2:0] ACT_FULL    = 3'd0;
    localparam logic [2:0] ACT_SHORT18 = 3'd1;
    localparam logic [2:0] ACT_SHORT   = 3'd2;
    localparam logic [2:0] ACT_TIMEOUT = 3'd3;

    // Packet types and protocol identifiers
    localparam logic [7:0] PT_CONNECT   = 8'd1;
    localparam logic [7:0] PT_DATA      = 8'd4;
    localparam logic [7:0] PROTO_STREAM = 8'd1;
    localparam logic [7:0] PROTO_DGRAM  = 8'd2;
    localparam logic [7:0] PROTO_RTX    = 8'd3;
    localparam logic [1:0] PEER_RTX     = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_STREAM_MODE = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SIZE_LIMIT  = 2'd2;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;
    localparam logic [15:0] SIZE_LIMIT_RST  = 16'd64000;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        K_DELIVER = 3'd0,
        K_CONACC  = 3'd1,
        K_ACK     = 3'd2,
        K_REJECT  = 3'd3,
        K_CONREJ  = 3'd4,
        K_RCVD    = 3'd5,
        K_CLOSE   = 3'd6
    } t_kind;

    typedef enum logic {
        S_IDLE      = 1'b0,
        S_CONNECTED = 1'b1
    } t_sess_state;

    typedef struct packed {
        logic        stream_mode;
        logic [7:0]  retry_limit;
        logic [15:0] size_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  packet_type;
        logic [7:0]  protocol_id;
        logic [63:0] session_id;
        logic [63:0] sequence_number;
        logic [63:0] total_bytes;
        logic [31:0] payload_bytes;
        logic        sender_matches;
    } t_item;

    // All results of one item share session, number and byte count; the
    // number applies to deliver, ack and reject, the byte count to deliver.
    typedef struct packed {
        logic [1:0]       cnt;
        t_kind [2:0]      kinds;
        logic [63:0]      session;
        logic [63:0]      number;
        logic [15:0]      bytes;
    } t_rec;

endpackage

[src/stop_and_wait_receiver_unit.sv]
// Top level of the stop-and-wait receiver: ports, configuration and wiring.
// One packet event is taken per cycle while the four-entry result queue has
// room; the session checks and state update finish in that cycle. Results
// leave one per cycle from the output register while the consumer is ready,
// so an event that yields n results (n from 0 to 3) holds the output side
// until all n have left, and the sustained rate is one event per cycle for
// events with at most one result while the output is not stalled. Results
// pass through the result queue and then the registered result port.
module stop_and_wait_receiver_unit import sawr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // packet_type, protocol_id, session_id, sequence_number, total_bytes,
    // payload_bytes, sender_matches, zero fill
    input  logic [247:0] i_s_axis_tdata,
    input  logic [2:0]   i_s_axis_tuser,   // action
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata,   // reply_session, reply_number, deliver_bytes
    output logic [2:0]   o_m_axis_tuser,   // reply_kind
    output logic         o_m_axis_tlast
);

    logic        r_stream_mode;
    logic [7:0]  r_retry_limit;
    logic [15:0] r_size_limit;

    t_cfg        cfg;
    t_item       item;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_rec        push_rec;
    t_rec        head_rec;
    t_kind       out_kind;
    logic [63:0] out_session;
    logic [63:0] out_number;
    logic [15:0] out_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_mode <= 1'b0;
            r_retry_limit <= RETRY_LIMIT_RST;
            r_size_limit  <= SIZE_LIMIT_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_STREAM_MODE: r_stream_mode <= i_cfg_wdata[0];
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[7:0];
                CFG_SIZE_LIMIT:  r_size_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.stream_mode = r_stream_mode;
    assign cfg.retry_limit = r_retry_limit;
    assign cfg.size_limit  = r_size_limit;

    assign item.action          = i_s_axis_tuser;
    assign item.packet_type     = i_s_axis_tdata[7:0];
    assign item.protocol_id     = i_s_axis_tdata[15:8];
    assign item.session_id      = i_s_axis_tdata[79:16];
    assign item.sequence_number = i_s_axis_tdata[143:80];
    assign item.total_bytes     = i_s_axis_tdata[207:144];
    assign item.payload_bytes   = i_s_axis_tdata[239:208];
    assign item.sender_matches  = i_s_axis_tdata[240];

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    sawr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_item   (item),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    sawr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    sawr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_rec     (head_rec),
        .o_pop     (pop),
        .i_ready   (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_kind    (out_kind),
        .o_session (out_session),
        .o_number  (out_number),
        .o_bytes   (out_bytes),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_bytes, out_number, out_session};
    assign o_m_axis_tuser = out_kind;

endmodule

[src/sawr_front.sv]
// Front end: session state, packet checks and result classification.
module sawr_front import sawr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_accept,
    input  t_item i_item,
    output logic  o_push,
    output t_rec  o_rec
);

    t_sess_state r_state, n_state;
    logic [63:0] r_session, n_session;
    logic [1:0]  r_peer, n_peer;
    logic [63:0] r_expected, n_expected;
    logic [63:0] r_remaining, n_remaining;
    logic [7:0]  r_retry, n_retry;

    logic        proto_ok;
    logic        rtx;
    logic        sess_eq;
    logic        seq_eq;
    logic        seq_gt;
    logic        pay_big;
    logic [63:0] pay_ext;
    logic [63:0] sat_left;
    logic        do_deliver;
    logic        do_ack;
    logic        chk_resend;
    t_rec        rec;

    assign pay_ext  = {32'd0, i_item.payload_bytes};
    assign proto_ok = i_cfg.stream_mode ? (i_item.protocol_id == PROTO_STREAM)
                    : (i_item.protocol_id == PROTO_DGRAM
                       || i_item.protocol_id == PROTO_RTX);
    assign rtx      = (r_peer == PEER_RTX);
    assign sess_eq  = (i_item.session_id == r_session);
    assign seq_eq   = (i_item.sequence_number == r_expected);
    assign seq_gt   = (i_item.sequence_number > r_expected);
    assign pay_big  = (i_item.payload_bytes > {16'd0, i_cfg.size_limit});
    // saturate remaining bytes at zero
    assign sat_left = (r_remaining > pay_ext) ? (r_remaining - pay_ext) : 64'd0;

    always_comb begin
        n_state     = r_state;
        n_session   = r_session;
        n_peer      = r_peer;
        n_expected  = r_expected;
        n_remaining = r_remaining;
        n_retry     = r_retry;
        do_deliver  = 1'b0;
        do_ack      = 1'b0;
        chk_resend  = 1'b0;
        rec         = '0;

        if (r_state == S_IDLE) begin
            if (i_item.action == ACT_FULL && i_item.packet_type == PT_CONNECT
                && proto_ok) begin
                n_session   = i_item.session_id;
                n_peer      = i_item.protocol_id[1:0];
                n_expected  = 64'd0;
                n_remaining = i_item.total_bytes;
                n_retry     = 8'd0;
                rec.cnt      = 2'd1;
                rec.kinds[0] = K_CONACC;
                rec.session  = i_item.session_id;
                n_state = (i_item.total_bytes != 64'd0) ? S_CONNECTED : S_IDLE;
            end
        end else if (i_cfg.stream_mode) begin
            if (i_item.action != ACT_FULL) begin
                rec.cnt = 2'd1; rec.kinds[0] = K_CLOSE; rec.session = r_session;
                n_state = S_IDLE;
            end else if (i_item.packet_type != PT_DATA || !sess_eq || !seq_eq
                         || pay_big) begin
                rec.cnt = 2'd1; rec.kinds[0] = K_REJECT;
                rec.session = i_item.session_id;
                rec.number  = i_item.sequence_number;
                n_state = S_IDLE;
            end else begin
                do_deliver = 1'b1;
            end
        end else begin
            if (i_item.action == ACT_TIMEOUT) begin
                if (!rtx || r_retry >= i_cfg.retry_limit) begin
                    rec.cnt = 2'd1; rec.kinds[0] = K_CLOSE; rec.session = r_session;
                    n_state = S_IDLE;
                end else begin
                    n_retry    = r_retry + 8'd1;
                    chk_resend = 1'b1;
                end
            end else if (i_item.action == ACT_SHORT || i_item.action > ACT_TIMEOUT
                         || (i_item.action == ACT_SHORT18 && !rtx)) begin
                rec.cnt = 2'd1; rec.kinds[0] = K_CLOSE; rec.session = r_session;
                n_state = S_IDLE;
            end else if (!i_item.sender_matches) begin
                // foreign sender: answer by type and drop the session
                rec.cnt = 2'd1;
                if (i_item.packet_type == PT_CONNECT) begin
                    rec.kinds[0] = K_CONREJ;
                    rec.session  = i_item.session_id;
                end else if (i_item.packet_type == PT_DATA) begin
                    rec.kinds[0] = K_REJECT;
                    rec.session  = i_item.session_id;
                    rec.number   = i_item.sequence_number;
                end else begin
                    rec.kinds[0] = K_CLOSE;
                    rec.session  = r_session;
                end
                n_state = S_IDLE;
            end else if ((i_item.packet_type != PT_DATA
                          && (!rtx || i_item.packet_type != PT_CONNECT))
                         || (i_item.packet_type == PT_DATA && !sess_eq)
                         || (i_item.packet_type == PT_DATA && !seq_eq
                             && (!rtx || seq_gt))
                         || (i_item.packet_type == PT_DATA && seq_eq && pay_big)) begin
                rec.cnt = 2'd1; rec.kinds[0] = K_REJECT;
                rec.session = i_item.session_id;
                rec.number  = i_item.sequence_number;
                n_state = S_IDLE;
            end else if (i_item.packet_type == PT_DATA && seq_eq) begin
                do_deliver = 1'b1;
                do_ack     = rtx;
            end else begin
                // duplicate connect or old number: keep the state, resend if retries are pending
                chk_resend = 1'b1;
            end
        end

        if (do_deliver) begin
            rec.kinds[0] = K_DELIVER;
            rec.session  = r_session;
            rec.number   = i_item.sequence_number;
            rec.bytes    = i_item.payload_bytes[15:0];
            n_retry      = 8'd0;
            n_expected   = r_expected + 64'd1;
            n_remaining  = sat_left;
            rec.cnt      = 2'd1;
            if (do_ack) begin
                rec.kinds[1] = K_ACK;
                rec.cnt      = 2'd2;
                if (sat_left == 64'd0) begin
                    rec.kinds[2] = K_RCVD;
                    rec.cnt      = 2'd3;
                end
            end else if (sat_left == 64'd0) begin
                rec.kinds[1] = K_RCVD;
                rec.cnt      = 2'd2;
            end
            if (sat_left == 64'd0) begin
                n_state = S_IDLE;
            end
        end

        // resend the last reply while retries are pending
        if (chk_resend && n_retry != 8'd0) begin
            rec.cnt      = 2'd1;
            rec.kinds[0] = (r_expected == 64'd0) ? K_CONACC : K_ACK;
            rec.session  = r_session;
            rec.number   = r_expected - 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_session   <= '0;
            r_peer      <= '0;
            r_expected  <= '0;
            r_remaining <= '0;
            r_retry     <= '0;
        end else if (i_accept) begin
            r_state     <= n_state;
            r_session   <= n_session;
            r_peer      <= n_peer;
            r_expected  <= n_expected;
            r_remaining <= n_remaining;
            r_retry     <= n_retry;
        end
    end

    assign o_push = i_accept && (rec.cnt != 2'd0);
    assign o_rec  = rec;

endmodule

[src/sawr_queue.sv]
// Short queue of result records between front and back.
module sawr_queue import sawr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

endmodule

[src/sawr_back.sv]
// Back end: unpacks each record into its results and drives the output register.
module sawr_back import sawr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_rec        i_rec,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output t_kind       o_kind,
    output logic [63:0] o_session,
    output logic [63:0] o_number,
    output logic [15:0] o_bytes,
    output logic        o_last
);

    logic [1:0]  r_idx;
    logic        r_valid;
    t_kind       r_kind;
    logic [63:0] r_session;
    logic [63:0] r_number;
    logic [15:0] r_bytes;
    logic        r_last;

    logic        load;
    logic        at_last;
    t_kind       cur_kind;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign cur_kind = i_rec.kinds[r_idx];
    assign at_last  = (r_idx == i_rec.cnt - 2'd1);
    assign o_pop    = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= cur_kind;
            r_session <= i_rec.session;
            r_number  <= (cur_kind == K_DELIVER || cur_kind == K_ACK
                          || cur_kind == K_REJECT) ? i_rec.number : 64'd0;
            r_bytes   <= (cur_kind == K_DELIVER) ? i_rec.bytes : 16'd0;
            r_last    <= at_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_session = r_session;
    assign o_number  = r_number;
    assign o_bytes   = r_bytes;
    assign o_last    = r_last;

endmodule

[src/sawr_checker.sv]
// Port-level checks on the result stream of the stop-and-wait receiver.
module sawr_checker import sawr_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [143:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
        && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result transaction changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= K_CLOSE)
        else $error("reply kind out of range");

    a_bytes_deliver_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != K_DELIVER |-> o_m_axis_tdata[143:128] == 16'd0)
        else $error("byte count on a non-deliver reply");

    a_number_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == K_CONACC || o_m_axis_tuser == K_CONREJ
        || o_m_axis_tuser == K_RCVD || o_m_axis_tuser == K_CLOSE)
        |-> o_m_axis_tdata[127:64] == 64'd0)
        else $error("packet number on a reply that carries none");

endmodule

bind stop_and_wait_receiver_unit sawr_checker u_sawr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
